/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge out of reset
`define SLGA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// overlapping implication sampled out of reset
`define SLGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/slga_pkg.sv */
// shared types, widths and constants of the sis lens amplification block
// no dependencies
`default_nettype none

package slga_pkg;

  // field widths
  localparam int FreqW    = 32;
  localparam int PosW     = 24;
  localparam int OutW     = 32;

  // reciprocal 2^56 / y, one quotient bit per stage
  localparam int InvW     = 57;
  localparam int DivSteps = InvW;

  // square roots, one root bit per stage
  localparam int RadW     = 58;
  localparam int RootW    = 29;
  localparam int RemW     = RootW + 2;

  // phase product and reduction modulo pi in q.44
  localparam int ProdW    = 56;
  localparam int PhShift  = 12;
  localparam int RedW     = 64;
  localparam int RedSteps = 19;
  localparam int RedDrop  = 13;
  localparam int PhaseW   = 33;
  localparam int PhaseLat = RedSteps + 2;

  // cordic datapath
  localparam int AngW     = 34;
  localparam int TrigW    = 32;
  localparam int AtanIdxW = 5;

  // latency of the root path and of the whole block
  localparam int CoreLat    = DivSteps + RootW;
  localparam int OutLatency = CoreLat + 2;

  localparam logic [PosW-1:0]  PosOne     = 24'h010000;
  localparam logic [RadW-1:0]  OneQ40     = 58'h100_0000_0000;
  localparam logic [RedW-1:0]  PiQ44      = 64'h0000_3243_F6A8_885A;
  localparam logic [AngW-1:0]  HalfPiQ30  = 34'h0_6487_ED51;
  localparam logic [AngW-1:0]  TpiQ30     = 34'h1_2D97_C7F3;
  localparam logic [AngW-1:0]  TwoPiQ30   = 34'h1_921F_B544;
  localparam logic [AngW-1:0]  PiQ30      = 34'h0_C90F_DAA2;
  localparam logic [AngW-1:0]  GainQ30    = 34'h0_26DD_3B6A;
  localparam logic [OutW-1:0]  OutMax     = 32'h7FFF_FFFF;
  localparam logic [OutW-1:0]  OutMin     = 32'h8000_0000;

  typedef struct packed {
    logic [FreqW-1:0] frequency;
    logic [PosW-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic signed [OutW-1:0] amp_real;
    logic signed [OutW-1:0] amp_imag;
    logic                   zero_position;
  } out_word_t;

  // case flags that travel beside the root path
  typedef struct packed {
    logic zero;
    logic ge_one;
  } side_t;

  // truncated atan(2^-i) in q.30
  function automatic logic [31:0] atan_q30(input logic [AtanIdxW-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/slga_delay.sv */
// fixed-depth register delay line for aligning pipeline branches
// no dependencies
`default_nettype none

module slga_delay #(
  parameter int Width = 1,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] dly_q [Depth];

  // shift line
  always_ff @(posedge clk_i) begin
    dly_q[0] <= data_i;
    for (int k = 1; k < Depth; k++) begin
      dly_q[k] <= dly_q[k-1];
    end
  end

  assign data_o = dly_q[Depth-1];

endmodule

`default_nettype wire

/* rtl/core/slga_div.sv */
// pipelined restoring divider computing floor(2^56 / y), one bit per stage
// depends on slga_pkg
`default_nettype none

module slga_div import slga_pkg::*; (
  input  logic            clk_i,
  input  logic [PosW-1:0] dvs_i,
  output logic [InvW-1:0] quot_o
);

  logic [PosW-1:0] rem_q   [DivSteps-1];
  logic [PosW-1:0] dvs_q   [DivSteps-1];
  logic [InvW-1:0] quot_q  [DivSteps];
  logic [PosW-1:0] rem_d   [DivSteps-1];
  logic [InvW-1:0] quot_d  [DivSteps];
  logic [PosW:0]   trial   [DivSteps];
  logic [PosW:0]   diff    [DivSteps];
  logic [PosW-1:0] dvs_in  [DivSteps];
  logic [InvW-1:0] quot_in [DivSteps];
  logic [DivSteps-1:0] ge;

  // stage inputs: the only set dividend bit enters at the first stage
  always_comb begin
    trial[0]   = {{PosW{1'b0}}, 1'b1};
    dvs_in[0]  = dvs_i;
    quot_in[0] = '0;
    for (int k = 1; k < DivSteps; k++) begin
      trial[k]   = {rem_q[k-1], 1'b0};
      dvs_in[k]  = dvs_q[k-1];
      quot_in[k] = quot_q[k-1];
    end
  end

  // compare and subtract per stage
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      ge[k]     = trial[k] >= {1'b0, dvs_in[k]};
      diff[k]   = trial[k] - {1'b0, dvs_in[k]};
      quot_d[k] = {quot_in[k][InvW-2:0], ge[k]};
    end
    for (int k = 0; k < DivSteps - 1; k++) begin
      rem_d[k] = ge[k] ? diff[k][PosW-1:0] : trial[k][PosW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DivSteps; k++) begin
      quot_q[k] <= quot_d[k];
    end
    for (int k = 0; k < DivSteps - 1; k++) begin
      rem_q[k] <= rem_d[k];
      dvs_q[k] <= dvs_in[k];
    end
  end

  assign quot_o = quot_q[DivSteps-1];

endmodule

`default_nettype wire

/* rtl/core/slga_sqrt.sv */
// pipelined floor integer square root, one root bit per stage
// depends on slga_pkg
`default_nettype none

module slga_sqrt import slga_pkg::*; (
  input  logic             clk_i,
  input  logic [RadW-1:0]  rad_i,
  output logic [RootW-1:0] root_o
);

  logic [RadW-1:0]  rad_q   [RootW-1];
  logic [RootW-1:0] rem_q   [RootW-1];
  logic [RootW-1:0] root_q  [RootW];
  logic [RootW-1:0] rem_d   [RootW-1];
  logic [RootW-1:0] root_d  [RootW];
  logic [RadW-1:0]  rad_in  [RootW];
  logic [RootW-1:0] rem_in  [RootW];
  logic [RootW-1:0] root_in [RootW];
  logic [RemW-1:0]  pair    [RootW];
  logic [RemW-1:0]  trial   [RootW];
  logic [RemW-1:0]  diff    [RootW];
  logic [RootW-1:0] ge;

  // stage inputs
  always_comb begin
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int j = 1; j < RootW; j++) begin
      rad_in[j]  = rad_q[j-1];
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
    end
  end

  // bring down two radicand bits, try 4*root+1
  always_comb begin
    for (int j = 0; j < RootW; j++) begin
      pair[j]   = {rem_in[j], rad_in[j][RadW-1 -: 2]};
      trial[j]  = {root_in[j], 2'b01};
      ge[j]     = pair[j] >= trial[j];
      diff[j]   = pair[j] - trial[j];
      root_d[j] = {root_in[j][RootW-2:0], ge[j]};
    end
    for (int j = 0; j < RootW - 1; j++) begin
      rem_d[j] = ge[j] ? diff[j][RootW-1:0] : pair[j][RootW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < RootW; j++) begin
      root_q[j] <= root_d[j];
    end
    for (int j = 0; j < RootW - 1; j++) begin
      rem_q[j] <= rem_d[j];
      rad_q[j] <= {rad_in[j][RadW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

`default_nettype wire

/* rtl/core/slga_phase.sv */
// phase path: w*y product, reduction modulo pi in q.44, fold to [-pi/2, pi/2]
// depends on slga_pkg
`default_nettype none

module slga_phase import slga_pkg::*; (
  input  logic                   clk_i,
  input  logic [FreqW-1:0]       freq_i,
  input  logic [PosW-1:0]        pos_i,
  output logic signed [AngW-1:0] ang_o,
  output logic                   neg_o
);

  logic [ProdW-1:0]  prod_q;
  logic [RedW-1:0]   red_q  [RedSteps];
  logic [RedW-1:0]   red_d  [RedSteps];
  logic [RedW-1:0]   red_in [RedSteps];
  logic [RedW-1:0]   sub    [RedSteps];
  logic [PhaseW-1:0] ph;
  logic [AngW-1:0]   ph_ext;
  logic [AngW-1:0]   ang_d;
  logic              neg_d;
  logic [AngW-1:0]   ang_q;
  logic              neg_q;

  // phase product
  always_ff @(posedge clk_i) begin
    prod_q <= freq_i * pos_i;
  end

  // conditional subtraction of pi*2^44 scaled down one power per stage
  always_comb begin
    red_in[0] = {prod_q[RedW-PhShift-1:0], {PhShift{1'b0}}};
    for (int k = 1; k < RedSteps; k++) begin
      red_in[k] = red_q[k-1];
    end
    for (int k = 0; k < RedSteps; k++) begin
      sub[k]   = PiQ44 << (RedSteps - 1 - k);
      red_d[k] = (red_in[k] >= sub[k]) ? red_in[k] - sub[k] : red_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RedSteps; k++) begin
      red_q[k] <= red_d[k];
    end
  end

  // fold the q.30 phase into the cordic range
  assign ph     = red_q[RedSteps-1][RedDrop +: PhaseW];
  assign ph_ext = {{(AngW-PhaseW){1'b0}}, ph};

  always_comb begin
    priority if (ph_ext < HalfPiQ30) begin
      ang_d = ph_ext;
      neg_d = 1'b0;
    end else if (ph_ext < TpiQ30) begin
      ang_d = ph_ext - PiQ30;
      neg_d = 1'b1;
    end else begin
      ang_d = ph_ext - TwoPiQ30;
      neg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
    neg_q <= neg_d;
  end

  assign ang_o = $signed(ang_q);
  assign neg_o = neg_q;

endmodule

`default_nettype wire

/* rtl/core/slga_cordic.sv */
// rotation-mode cordic, one micro-rotation per pipeline stage
// depends on slga_pkg
`default_nettype none

module slga_cordic import slga_pkg::*; #(
  parameter int Stages = 20
) (
  input  logic                    clk_i,
  input  logic signed [AngW-1:0]  ang_i,
  input  logic                    neg_i,
  output logic signed [TrigW-1:0] sin_o,
  output logic signed [TrigW-1:0] cos_o
);

  logic signed [AngW-1:0] x_q   [Stages];
  logic signed [AngW-1:0] y_q   [Stages];
  logic signed [AngW-1:0] th_q  [Stages-1];
  logic                   neg_q [Stages];
  logic signed [AngW-1:0] x_d   [Stages];
  logic signed [AngW-1:0] y_d   [Stages];
  logic signed [AngW-1:0] th_d  [Stages];
  logic signed [AngW-1:0] x_in  [Stages];
  logic signed [AngW-1:0] y_in  [Stages];
  logic signed [AngW-1:0] th_in [Stages];
  logic                   neg_in [Stages];
  logic signed [AngW-1:0] at    [Stages];
  logic signed [AngW-1:0] x_fin;
  logic signed [AngW-1:0] y_fin;

  // stage inputs, start vector is (gain, 0)
  always_comb begin
    x_in[0]   = $signed(GainQ30);
    y_in[0]   = '0;
    th_in[0]  = ang_i;
    neg_in[0] = neg_i;
    for (int i = 1; i < Stages; i++) begin
      x_in[i]   = x_q[i-1];
      y_in[i]   = y_q[i-1];
      th_in[i]  = th_q[i-1];
      neg_in[i] = neg_q[i-1];
    end
  end

  // micro-rotation toward zero residual angle
  always_comb begin
    for (int i = 0; i < Stages; i++) begin
      at[i] = $signed({{(AngW-32){1'b0}}, atan_q30(AtanIdxW'(i))});
      if (!th_in[i][AngW-1]) begin
        x_d[i]  = x_in[i] - (y_in[i] >>> i);
        y_d[i]  = y_in[i] + (x_in[i] >>> i);
        th_d[i] = th_in[i] - at[i];
      end else begin
        x_d[i]  = x_in[i] + (y_in[i] >>> i);
        y_d[i]  = y_in[i] - (x_in[i] >>> i);
        th_d[i] = th_in[i] + at[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Stages; i++) begin
      x_q[i]   <= x_d[i];
      y_q[i]   <= y_d[i];
      neg_q[i] <= neg_in[i];
    end
    for (int i = 0; i < Stages - 1; i++) begin
      th_q[i] <= th_d[i];
    end
  end

  // undo the fold by half a turn
  assign x_fin = neg_q[Stages-1] ? -x_q[Stages-1] : x_q[Stages-1];
  assign y_fin = neg_q[Stages-1] ? -y_q[Stages-1] : y_q[Stages-1];
  assign sin_o = y_fin[TrigW-1:0];
  assign cos_o = x_fin[TrigW-1:0];

endmodule

`default_nettype wire

/* rtl/core/sis_lens_geometric_amplification.sv */
// top level of the sis lens geometric-optics amplification factor pipeline
// depends on slga_pkg, slga_div, slga_sqrt, slga_phase, slga_cordic, slga_delay
//
// Usage:
//   A word (frequency w in Q16.16, position y in Q8.16) is taken on in_i at
//   every rising edge with start_i high and busy_o low. busy_o is always low:
//   the pipeline takes a new word in every cycle, one word per cycle sustained.
//   Each result word appears on out_o for exactly one cycle with done_o high,
//   in input order, after the divider, root, multiply and add/saturate stages.
//   The receiver cannot stall, so nothing ever holds the pipeline.
//   Latency is set by the root path: 57 stages of the reciprocal divider
//   (one quotient bit each), 29 stages of square root (one root bit each),
//   then one multiply stage and one add/saturate stage. The phase path
//   (product, 19 reduction stages, fold, CORDIC_STAGES cordic stages) runs
//   alongside and is delayed to meet the roots.
//   Reset clears all valid bits; no result is shown until a word is taken
//   after reset. Data registers hold no reset value.
//   Position zero gives saturated outputs and zero_position set.
`default_nettype none

module sis_lens_geometric_amplification import slga_pkg::*; #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_word_t  in_i,
  output logic      done_o,
  output out_word_t out_o
);

  localparam int TrigDly = CoreLat - PhaseLat - CORDIC_STAGES;
  localparam int ProdSW  = RootW + 1 + TrigW;
  localparam int FracSh  = 30;
  localparam int SumW    = OutW + 2;

  logic [OutLatency-1:0]   vld_q;
  logic [InvW-1:0]         inv;
  logic [RadW-1:0]         rad_a;
  logic [RadW-1:0]         rad_b;
  logic [RootW-1:0]        root_a;
  logic [RootW-1:0]        root_b;
  logic signed [AngW-1:0]  ang;
  logic                    ang_neg;
  logic signed [TrigW-1:0] sin_c;
  logic signed [TrigW-1:0] cos_c;
  logic [2*TrigW-1:0]      trig_dly;
  side_t                   side_in;
  side_t                   side_dly;
  side_t                   side_q;
  logic [RootW-1:0]        a_q;
  logic signed [ProdSW-1:0] prod_s_q;
  logic signed [ProdSW-1:0] prod_c_q;
  logic [SumW-1:0]         sum_re;
  logic [SumW-1:0]         sum_im;
  out_word_t               out_d;
  out_word_t               out_q;

  function automatic logic [OutW-1:0] sat_out(input logic [SumW-1:0] v);
    logic [OutW-1:0] r;
    priority if (v[SumW-1] && !(&v[SumW-2:OutW-1])) begin
      r = OutMin;
    end else if (!v[SumW-1] && (|v[SumW-2:OutW-1])) begin
      r = OutMax;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  assign busy_o = 1'b0;

  // valid bits beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[OutLatency-2:0], start_i && !busy_o};
    end
  end

  // root path: reciprocal then both radicands
  slga_div u_div (
    .clk_i  (clk_i),
    .dvs_i  (in_i.position),
    .quot_o (inv)
  );

  assign rad_a = OneQ40 + {{(RadW-InvW){1'b0}}, inv};
  assign rad_b = {{(RadW-InvW){1'b0}}, inv} - OneQ40;

  slga_sqrt u_sqrt_a (
    .clk_i  (clk_i),
    .rad_i  (rad_a),
    .root_o (root_a)
  );

  slga_sqrt u_sqrt_b (
    .clk_i  (clk_i),
    .rad_i  (rad_b),
    .root_o (root_b)
  );

  // case flags follow the root path
  assign side_in.zero   = (in_i.position == '0);
  assign side_in.ge_one = (in_i.position >= PosOne);

  slga_delay #(
    .Width ($bits(side_t)),
    .Depth (CoreLat)
  ) u_side_dly (
    .clk_i  (clk_i),
    .data_i (side_in),
    .data_o (side_dly)
  );

  // phase path and sin/cos
  slga_phase u_phase (
    .clk_i  (clk_i),
    .freq_i (in_i.frequency),
    .pos_i  (in_i.position),
    .ang_o  (ang),
    .neg_o  (ang_neg)
  );

  slga_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_cordic (
    .clk_i (clk_i),
    .ang_i (ang),
    .neg_i (ang_neg),
    .sin_o (sin_c),
    .cos_o (cos_c)
  );

  slga_delay #(
    .Width (2 * TrigW),
    .Depth (TrigDly)
  ) u_trig_dly (
    .clk_i  (clk_i),
    .data_i ({sin_c, cos_c}),
    .data_o (trig_dly)
  );

  // b*sin and b*cos
  always_ff @(posedge clk_i) begin
    a_q      <= root_a;
    side_q   <= side_dly;
    prod_s_q <= $signed({1'b0, root_b}) * $signed(trig_dly[2*TrigW-1:TrigW]);
    prod_c_q <= $signed({1'b0, root_b}) * $signed(trig_dly[TrigW-1:0]);
  end

  // floor to q.20, add, saturate, pick the special cases
  assign sum_re = {{(SumW-RootW){1'b0}}, a_q}
                + {{(SumW-OutW){prod_s_q[ProdSW-1]}}, prod_s_q[FracSh +: OutW]};
  assign sum_im = {SumW{1'b0}}
                - {{(SumW-OutW){prod_c_q[ProdSW-1]}}, prod_c_q[FracSh +: OutW]};

  always_comb begin
    priority if (side_q.zero) begin
      out_d.amp_real      = OutMax;
      out_d.amp_imag      = OutMin;
      out_d.zero_position = 1'b1;
    end else if (side_q.ge_one) begin
      out_d.amp_real      = sat_out({{(SumW-RootW){1'b0}}, a_q});
      out_d.amp_imag      = '0;
      out_d.zero_position = 1'b0;
    end else begin
      out_d.amp_real      = sat_out(sum_re);
      out_d.amp_imag      = sat_out(sum_im);
      out_d.zero_position = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o  = out_q;
  assign done_o = vld_q[OutLatency-1];

endmodule

`default_nettype wire

/* rtl/core/slga_checker.sv */
// port-level checks of the amplification pipeline, bound to the top level
// depends on slga_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module slga_checker import slga_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input in_word_t  in_i,
  input logic      done_o,
  input out_word_t out_o
);

  // a result only ever follows a word taken a fixed latency earlier
  `SLGA_ASSERT_IMP(a_done_has_word, clk_i, rst_ni, done_o, $past(start_i && !busy_o, OutLatency), "result without a word taken at the pipeline latency")

  // the flag follows the position of that word
  `SLGA_ASSERT_IMP(a_flag_matches, clk_i, rst_ni, done_o, out_o.zero_position == $past(in_i.position == '0, OutLatency), "zero_position does not match the position taken")

  // zero position drives both parts to saturation
  `SLGA_ASSERT_IMP(a_zero_sat, clk_i, rst_ni, done_o && out_o.zero_position, (out_o.amp_real == OutMax) && (out_o.amp_imag == OutMin), "zero position result not saturated")

  // a position of one or more leaves no imaginary part
  `SLGA_ASSERT_IMP(a_far_real, clk_i, rst_ni, done_o && $past(in_i.position >= PosOne, OutLatency), out_o.amp_imag == '0, "imaginary part set for position of one or more")

endmodule

bind sis_lens_geometric_amplification slga_checker u_checker (.*);

`default_nettype wire

/* bench/tb_sis_lens_geometric_amplification.sv */
// testbench of the sis lens geometric-optics amplification factor pipeline
// depends on slga_pkg and sis_lens_geometric_amplification
`timescale 1ns / 100ps

module tb_sis_lens_geometric_amplification;
  import slga_pkg::*;

  localparam int Stages   = 20;
  localparam int Latency  = 88;
  localparam int Watchdog = 5000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  logic      busy_o;
  in_word_t  in_i = '0;
  logic      done_o;
  out_word_t out_o;

  out_word_t amp_q[$];
  int        errors = 0;
  int        idle_cycles = 0;

  sis_lens_geometric_amplification #(.CORDIC_STAGES(Stages)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .done_o, .out_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // arithmetic shift that floors
  function automatic logic signed [127:0] fl_shr(logic signed [127:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return OutMax;
    if (v < -128'sd2147483648) return OutMin;
    return v[31:0];
  endfunction

  // expected amplification factor of one word
  function automatic out_word_t lens_factor(in_word_t w);
    out_word_t r;
    logic [63:0] inv, a, b, red;
    logic signed [127:0] th, x, y, nx, ny, s, c, re, im;
    logic neg;
    r = '0;
    if (w.position == 0) begin
      r.amp_real = OutMax;
      r.amp_imag = OutMin;
      r.zero_position = 1'b1;
      return r;
    end
    inv = (64'd1 << 56) / w.position;
    a = isqrt((64'd1 << 40) + inv);
    if (w.position >= PosOne) begin
      r.amp_real = clamp32($signed({64'd0, a}));
      r.amp_imag = '0;
      return r;
    end
    b = isqrt(inv - (64'd1 << 40));
    red = ((64'(w.frequency) * 64'(w.position)) << PhShift) % PiQ44;
    th = $signed({64'd0, red >> RedDrop});
    neg = 1'b0;
    // fold the phase into [-pi/2, pi/2]
    if (th < $signed({94'd0, HalfPiQ30})) begin
    end else if (th < $signed({94'd0, TpiQ30})) begin
      th = th - $signed({94'd0, PiQ30});
      neg = 1'b1;
    end else begin
      th = th - $signed({94'd0, TwoPiQ30});
    end
    x = $signed({94'd0, GainQ30});
    y = 0;
    for (int i = 0; i < Stages && i < 32; i++) begin
      if (th >= 0) begin
        nx = x - fl_shr(y, i);
        ny = y + fl_shr(x, i);
        th = th - $signed({96'd0, atan_q30(i[4:0])});
      end else begin
        nx = x + fl_shr(y, i);
        ny = y - fl_shr(x, i);
        th = th + $signed({96'd0, atan_q30(i[4:0])});
      end
      x = nx;
      y = ny;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
    re = $signed({64'd0, a}) + fl_shr($signed({64'd0, b}) * s, 30);
    im = -fl_shr($signed({64'd0, b}) * c, 30);
    r.amp_real = clamp32(re);
    r.amp_imag = clamp32(im);
    return r;
  endfunction

  // mostly short gaps, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // send one word, waiting for the handshake; start stays high on return
  task automatic send_word(logic [31:0] freq, logic [23:0] pos);
    in_word_t w;
    w.frequency = freq;
    w.position = pos;
    start_i <= 1'b1;
    in_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    amp_q.push_back(lens_factor(w));
    @(negedge clk_i);
  endtask

  task automatic send_gapped(logic [31:0] freq, logic [23:0] pos, bit gaps);
    int g;
    send_word(freq, pos);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && done_o) begin
      if (amp_q.size() == 0) begin
        $display("%0t: unexpected word real=%h imag=%h zero=%b", $time,
                 out_o.amp_real, out_o.amp_imag, out_o.zero_position);
        errors++;
      end else begin
        exp_w = amp_q.pop_front();
        if (out_o.amp_real !== exp_w.amp_real) begin
          $display("%0t: amp_real expected %h actual %h", $time,
                   exp_w.amp_real, out_o.amp_real);
          errors++;
        end
        if (out_o.amp_imag !== exp_w.amp_imag) begin
          $display("%0t: amp_imag expected %h actual %h", $time,
                   exp_w.amp_imag, out_o.amp_imag);
          errors++;
        end
        if (out_o.zero_position !== exp_w.zero_position) begin
          $display("%0t: zero_position expected %b actual %b", $time,
                   exp_w.zero_position, out_o.zero_position);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word either way
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    send_gapped(32'h0, 24'h0, 0);
    send_gapped(32'hFFFF_FFFF, 24'h0, 0);
    send_gapped(32'h0, 24'h1, 0);
    send_gapped(32'hFFFF_FFFF, 24'h1, 0);
    send_gapped(32'h1234_5678, 24'h00FFFF, 0);
    send_gapped(32'h0001_0000, 24'h010000, 0);
    send_gapped(32'hFFFF_FFFF, 24'h010001, 0);
    send_gapped(32'h0, 24'hFFFFFF, 0);
    send_gapped(32'hFFFF_FFFF, 24'hFFFFFF, 0);
    send_gapped(32'h0000_0001, 24'h008000, 0);
    send_gapped(32'hFFFF_FFFF, 24'h00FFFF, 0);
    send_gapped(32'h0003_243F, 24'h008000, 0);
    send_gapped(32'h0001_921F, 24'h008000, 0);
    send_gapped(32'h0004_B65F, 24'h008000, 0);
    send_gapped(32'hAAAA_AAAA, 24'h555555, 0);
    send_gapped(32'h5555_5555, 24'h00AAAA, 0);
    send_gapped(32'h8000_0000, 24'h000002, 0);
    send_gapped(32'h0000_0000, 24'h00C000, 0);
  endtask

  task automatic test_random(int n);
    logic [31:0] f;
    logic [23:0] p;
    for (int i = 0; i < n; i++) begin
      f = $urandom;
      case ($urandom_range(0, 9))
        0: p = 24'($urandom_range(0, 3));
        1, 2: p = 24'($urandom_range(24'h010000, 24'hFFFFFF));
        3: p = 24'($urandom_range(24'h00FFF0, 24'h010010));
        default: p = 24'($urandom_range(1, 24'h00FFFF));
      endcase
      if ($urandom_range(0, 7) == 0) f = $urandom_range(0, 32'h0004_0000);
      // back-to-back stretches now and then
      send_gapped(f, p, (i / 40) % 3 != 1);
    end
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (amp_q.size() != 0);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    drain();
    test_random(320);
    drain();
    test_random(320);
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0 && amp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/slga_pkg.sv
rtl/core/slga_delay.sv
rtl/core/slga_div.sv
rtl/core/slga_sqrt.sv
rtl/core/slga_phase.sv
rtl/core/slga_cordic.sv
rtl/core/sis_lens_geometric_amplification.sv
rtl/core/slga_checker.sv
bench/tb_sis_lens_geometric_amplification.sv
